// File: rtl/output_blink_pattern_generator_macros.svh
// assertion macros for the blink pattern generator
`ifndef OUTPUT_BLINK_PATTERN_GENERATOR_MACROS_SVH
`define OUTPUT_BLINK_PATTERN_GENERATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clock, idle during reset
`define OBPG_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, idle during reset
`define OBPG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define OBPG_ASSERT_SAME(label, ante, cons, msg)
`define OBPG_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: rtl/obpg_pkg.sv
// types and constants of the blink pattern generator
package obpg_pkg;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned CFG_W   = 16;
   localparam int unsigned MODE_W  = 3;
   localparam int unsigned ADDR_W  = 4;
   localparam int unsigned DATA_W  = 32;

   // blink modes, codes 5 to 7 are unused
   typedef enum logic [MODE_W-1:0] {
      MODE_OFF     = 3'd0,
      MODE_ON      = 3'd1,
      MODE_BLINK   = 3'd2,
      MODE_LIMITED = 3'd3,
      MODE_BURSTS  = 3'd4
   } mode_type;

   // register index, byte address divided by four
   typedef enum logic [1:0] {
      REG_ON_TIME    = 2'd0,
      REG_OFF_TIME   = 2'd1,
      REG_PAUSE_TIME = 2'd2,
      REG_PULSE_LIM  = 2'd3
   } reg_index_type;

   localparam logic [CFG_W-1:0] ON_TIME_RESET    = 16'd500;
   localparam logic [CFG_W-1:0] OFF_TIME_RESET   = 16'd500;
   localparam logic [CFG_W-1:0] PAUSE_TIME_RESET = 16'd2000;
   localparam logic [CFG_W-1:0] PULSE_LIM_RESET  = 16'd3;

endpackage

// File: rtl/output_blink_pattern_generator.sv
// Blink pattern generator: one output level per timestamp and mode word.
// Path: a word accepted into the input register passes through the state update
// into the result register, where it is held until taken.
// Throughput: one word per cycle while rsp_stall is low; the state update feeds back from the state registers.
// Reset: synchronous, clears pipeline valids, mode, counter, timing and level,
// and loads the configuration registers with their default times and limit.
`include "output_blink_pattern_generator_macros.svh"

module output_blink_pattern_generator (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [obpg_pkg::TIME_W-1:0]   req_now_ms,
   input  logic [obpg_pkg::MODE_W-1:0]   req_blink_mode,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_drive_level,
   // configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [obpg_pkg::ADDR_W-1:0]   paddr,
   input  logic [obpg_pkg::DATA_W-1:0]   pwdata,
   output logic [obpg_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);
   import obpg_pkg::*;

   // configuration registers
   logic [CFG_W-1:0]  on_time_ff;
   logic [CFG_W-1:0]  off_time_ff;
   logic [CFG_W-1:0]  pause_time_ff;
   logic [CFG_W-1:0]  pulse_lim_ff;
   logic              cfg_write;
   reg_index_type     cfg_index;

   // input register
   logic              in_valid_ff;
   logic [TIME_W-1:0] in_now_ff;
   logic [MODE_W-1:0] in_mode_ff;

   // state and result
   logic              out_valid_ff;
   logic [MODE_W-1:0] prev_mode_ff;
   logic [MODE_W-1:0] prev_mode_in;
   logic [CFG_W-1:0]  pulse_count_ff;
   logic [CFG_W-1:0]  pulse_count_in;
   logic [TIME_W-1:0] last_change_ff;
   logic [TIME_W-1:0] last_change_in;
   logic              level_ff;
   logic              level_in;

   logic              out_load;
   logic              in_load;

   // configuration access
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign cfg_index = reg_index_type'(paddr[ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         on_time_ff    <= ON_TIME_RESET;
         off_time_ff   <= OFF_TIME_RESET;
         pause_time_ff <= PAUSE_TIME_RESET;
         pulse_lim_ff  <= PULSE_LIM_RESET;
      end else if (cfg_write) begin
         unique case (cfg_index)
            REG_ON_TIME:    on_time_ff    <= pwdata[CFG_W-1:0];
            REG_OFF_TIME:   off_time_ff   <= pwdata[CFG_W-1:0];
            REG_PAUSE_TIME: pause_time_ff <= pwdata[CFG_W-1:0];
            REG_PULSE_LIM:  pulse_lim_ff  <= pwdata[CFG_W-1:0];
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (cfg_index)
         REG_ON_TIME:    prdata = {{(DATA_W-CFG_W){1'b0}}, on_time_ff};
         REG_OFF_TIME:   prdata = {{(DATA_W-CFG_W){1'b0}}, off_time_ff};
         REG_PAUSE_TIME: prdata = {{(DATA_W-CFG_W){1'b0}}, pause_time_ff};
         REG_PULSE_LIM:  prdata = {{(DATA_W-CFG_W){1'b0}}, pulse_lim_ff};
      endcase
   end

   // pipeline flow: result register loads when empty or being taken
   assign out_load  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !out_load;
   assign in_load   = req_valid && !req_stall;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= 1'b1;
      end else if (out_load) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_now_ff  <= req_now_ms;
         in_mode_ff <= req_blink_mode;
      end
   end

   // per-word state update
   always_comb begin
      logic              changed;
      logic [CFG_W-1:0]  count_base;
      logic [TIME_W-1:0] change_base;
      logic [TIME_W-1:0] elapsed;
      logic              on_over;
      logic              off_over;
      logic              pause_over;
      logic              blink_level;
      logic              blink_bump;

      changed     = (in_mode_ff != prev_mode_ff);
      count_base  = changed ? '0 : pulse_count_ff;
      change_base = changed ? in_now_ff : last_change_ff;
      elapsed     = in_now_ff - change_base;
      on_over     = elapsed > {{(TIME_W-CFG_W){1'b0}}, on_time_ff};
      off_over    = elapsed > {{(TIME_W-CFG_W){1'b0}}, off_time_ff};
      pause_over  = elapsed > {{(TIME_W-CFG_W){1'b0}}, pause_time_ff};

      // one blink step from the current level
      blink_level = level_ff ? !on_over : off_over;
      blink_bump  = !level_ff && off_over;

      prev_mode_in   = in_mode_ff;
      pulse_count_in = count_base;
      last_change_in = change_base;
      level_in       = level_ff;

      unique case (in_mode_ff)
         MODE_OFF: level_in = 1'b0;
         MODE_ON:  level_in = 1'b1;
         MODE_BLINK: begin
            level_in       = blink_level;
            pulse_count_in = count_base + CFG_W'(blink_bump);
         end
         MODE_LIMITED: begin
            if (count_base < pulse_lim_ff) begin
               level_in       = blink_level;
               pulse_count_in = count_base + CFG_W'(blink_bump);
            end else begin
               level_in = 1'b0;
            end
         end
         MODE_BURSTS: begin
            if (count_base <= pulse_lim_ff) begin
               level_in       = blink_level;
               pulse_count_in = count_base + CFG_W'(blink_bump);
            end else begin
               level_in = 1'b0;
               if (pause_over) begin
                  last_change_in = in_now_ff;
                  pulse_count_in = '0;
               end
            end
         end
         default: level_in = level_ff;
      endcase

      // any level edge restarts timing
      if (level_in != level_ff) begin
         last_change_in = in_now_ff;
      end
   end

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         prev_mode_ff   <= MODE_OFF;
         pulse_count_ff <= '0;
         last_change_ff <= '0;
         level_ff       <= 1'b0;
      end else begin
         if (out_load) begin
            out_valid_ff   <= 1'b1;
            prev_mode_ff   <= prev_mode_in;
            pulse_count_ff <= pulse_count_in;
            last_change_ff <= last_change_in;
            level_ff       <= level_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_drive_level = level_ff;

   // checks on the state update
   `OBPG_ASSERT_NEXT(off_forces_low, out_load && (in_mode_ff == MODE_OFF), rsp_valid && !rsp_drive_level, "off mode gave a high level")
   `OBPG_ASSERT_NEXT(on_forces_high, out_load && (in_mode_ff == MODE_ON), rsp_valid && rsp_drive_level, "on mode gave a low level")
   `OBPG_ASSERT_NEXT(change_clears_count, out_load && (in_mode_ff != prev_mode_ff), (pulse_count_ff == '0) || (pulse_count_ff == CFG_W'(1)), "mode change left a stale pulse count")
   `OBPG_ASSERT_NEXT(unused_mode_holds, out_load && (in_mode_ff > MODE_BURSTS), $stable(level_ff), "unused mode changed the level")
   `OBPG_ASSERT_SAME(stall_needs_word, req_stall, in_valid_ff, "input stalled with an empty input register")

endmodule
